// ===== hdl/rs_systematic_encoder_assert.svh =====
// assertion macros shared by the encoder checker
`ifndef RS_SYSTEMATIC_ENCODER_ASSERT_SVH
`define RS_SYSTEMATIC_ENCODER_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define RSE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rse assertion failed");

// next-cycle implication, quiet while reset is high
`define RSE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rse assertion failed");

// next-cycle implication that is also checked during reset
`define RSE_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rse assertion failed");

`endif

// ===== hdl/rse_pkg.sv =====
// shared types, constants and gf(256) arithmetic for the rs encoder
`default_nettype none

package rse_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARITY_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_POLY   = 2'd1;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 6;

   // low byte of 0x11d, the x^8 term is implied
   localparam logic [BYTE_W-1:0] FIELD_POLY_RESET = 8'h1D;
   localparam logic [BYTE_W-1:0] ALPHA            = 8'h02;
   localparam logic [BYTE_W-1:0] GF_ONE           = 8'h01;

   // generator build control toward the lanes
   typedef struct packed {
      logic              clear;
      logic              step;
      logic [BYTE_W-1:0] root;
      logic [BYTE_W-1:0] poly_low;
   } rse_gen_ctl_type;

   // parity register control toward the lanes
   typedef struct packed {
      logic              step;
      logic              shift;
      logic              clear;
      logic [BYTE_W-1:0] fb;
   } rse_par_ctl_type;

   // shift-and-add multiply modulo x^8 + poly_low
   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [BYTE_W-1:0] poly_low);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] x;
      acc = '0;
      x   = a;
      for (int i = 0; i < BYTE_W; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = x[BYTE_W-1] ? ({x[BYTE_W-2:0], 1'b0} ^ poly_low) : {x[BYTE_W-2:0], 1'b0};
      end
      return acc;
   endfunction

   // multiply by alpha
   function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] poly_low);
      return a[BYTE_W-1] ? ({a[BYTE_W-2:0], 1'b0} ^ poly_low) : {a[BYTE_W-2:0], 1'b0};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rse_cfg.sv =====
// configuration registers and generator build sequencer
`default_nettype none

module rse_cfg #(
   parameter int MAX_LEN = 63
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [rse_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [rse_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [rse_pkg::COUNT_W-1:0]          parity_count,
   output logic                                 building,
   output rse_pkg::rse_gen_ctl_type             gen_ctl
);
   import rse_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  poly_ff, poly_in;
   logic               build_ff, build_in;
   logic [BYTE_W-1:0]  root_ff, root_in;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic               restart;

   // register writes; only the low six data bits hold a parity count, which is dropped if above MAX_LEN
   always_comb begin
      count_in = count_ff;
      poly_in  = poly_ff;
      restart  = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PARITY_COUNT: begin
               if (csr_wdata[COUNT_W-1:0] <= COUNT_W'(MAX_LEN)) begin
                  count_in = csr_wdata[COUNT_W-1:0];
                  restart  = 1'b1;
               end
            end
            CSR_FIELD_POLY: begin
               poly_in = csr_wdata[BYTE_W-1:0];
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // one factor (x + alpha^i) folded in per cycle
   always_comb begin
      build_in = build_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      if (restart) begin
         build_in = (count_in != '0);
         root_in  = ALPHA;
         step_in  = '0;
      end else if (build_ff) begin
         root_in = gf_xtime(root_ff, poly_ff);
         step_in = step_ff + 1'b1;
         if (step_ff == count_ff - 1'b1) begin
            build_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         poly_ff  <= FIELD_POLY_RESET;
         build_ff <= 1'b0;
         root_ff  <= ALPHA;
         step_ff  <= '0;
      end else begin
         count_ff <= count_in;
         poly_ff  <= poly_in;
         build_ff <= build_in;
         root_ff  <= root_in;
         step_ff  <= step_in;
      end
   end

   assign parity_count     = count_ff;
   assign building         = build_ff;
   assign gen_ctl.clear    = restart;
   assign gen_ctl.step     = build_ff & ~restart;
   assign gen_ctl.root     = root_ff;
   assign gen_ctl.poly_low = poly_ff;

endmodule

`default_nettype wire

// ===== hdl/rse_lanes.sv =====
// generator and parity registers, one gf multiplier per lane
`default_nettype none

// both polynomials sit top-aligned: the highest used register is always
// lane MAX_LEN-1 and lanes below the degree stay zero
module rse_lanes #(
   parameter int MAX_LEN = 63
) (
   input  wire                                clock,
   input  wire                                reset,
   input  rse_pkg::rse_gen_ctl_type           gen_ctl,
   input  rse_pkg::rse_par_ctl_type           par_ctl,
   output logic [rse_pkg::BYTE_W-1:0]         par_top
);
   import rse_pkg::*;

   logic [MAX_LEN-1:0][BYTE_W-1:0] gen_ff, gen_in;
   logic [MAX_LEN-1:0][BYTE_W-1:0] par_ff, par_in;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_lane
      logic [BYTE_W-1:0] gen_up;
      logic [BYTE_W-1:0] par_dn;
      logic [BYTE_W-1:0] mul_a;
      logic [BYTE_W-1:0] mul_b;
      logic [BYTE_W-1:0] prod;

      // neighbor taps; the monic top term sits above the last lane
      if (i == MAX_LEN - 1) begin : g_top
         assign gen_up = GF_ONE;
      end else begin : g_mid
         assign gen_up = gen_ff[i+1];
      end
      if (i == 0) begin : g_bot
         assign par_dn = '0;
      end else begin : g_up
         assign par_dn = par_ff[i-1];
      end

      // shared multiplier: generator build or parity feedback
      assign mul_a = gen_ctl.step ? gen_up : gen_ff[i];
      assign mul_b = gen_ctl.step ? gen_ctl.root : par_ctl.fb;
      assign prod  = gf_mul(mul_a, mul_b, gen_ctl.poly_low);

      assign gen_in[i] = gen_ctl.clear ? '0 :
                         gen_ctl.step  ? (gen_ff[i] ^ prod) : gen_ff[i];

      assign par_in[i] = par_ctl.clear ? '0 :
                         par_ctl.step  ? (par_dn ^ prod) :
                         par_ctl.shift ? par_dn : par_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0;
         par_ff <= '0;
      end else begin
         gen_ff <= gen_in;
         par_ff <= par_in;
      end
   end

   assign par_top = par_ff[MAX_LEN-1];

endmodule

`default_nettype wire

// ===== hdl/rs_systematic_encoder.sv =====
// systematic reed-solomon encoder over gf(256), top level
// a message byte passes the s1 register and then the result register on its way to rsp
// throughput: one byte per cycle while rsp_ready is high; a final byte without error is followed by
//   n lfsr parity bytes (n = parity count) via the single result register, req_ready low while s1 waits
// a parity count or polynomial write rebuilds the generator, with req_ready low while it builds
// reset (synchronous): parity count 0, polynomial 0x11d, lfsr and byte count cleared
`default_nettype none

module rs_systematic_encoder #(
   parameter int MAX_LEN = 63
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [7:0]                        req_data_byte,
   input  wire                               req_msg_end,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_is_parity,
   output logic                              rsp_error,
   output logic                              rsp_out_last,
   input  wire                               csr_wr_en,
   input  wire  [rse_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [rse_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rse_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 2);

   logic [COUNT_W-1:0] parity_count;
   logic               building;
   rse_gen_ctl_type    gen_ctl;
   rse_par_ctl_type    par_ctl;
   logic [BYTE_W-1:0]  par_top;

   logic               s1_vld_ff, s1_vld_in;
   logic [BYTE_W-1:0]  s1_data_ff;
   logic               s1_end_ff;
   logic [CNT_W-1:0]   bcnt_ff, bcnt_in;
   logic               drain_ff, drain_in;
   logic [COUNT_W-1:0] dcnt_ff, dcnt_in;
   logic               out_vld_ff, out_vld_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_par_ff, out_par_in;
   logic               out_err_ff, out_err_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic               s1_adv;
   logic               drain_emit;
   logic [CNT_W-1:0]   bcnt_next;
   logic               msg_err;

   rse_cfg #(.MAX_LEN(MAX_LEN)) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .parity_count (parity_count),
      .building     (building),
      .gen_ctl      (gen_ctl)
   );

   rse_lanes #(.MAX_LEN(MAX_LEN)) u_lanes (
      .clock   (clock),
      .reset   (reset),
      .gen_ctl (gen_ctl),
      .par_ctl (par_ctl),
      .par_top (par_top)
   );

   // handshake
   assign out_free   = ~out_vld_ff | rsp_ready;
   assign s1_adv     = s1_vld_ff & ~drain_ff & ~building & out_free;
   assign drain_emit = drain_ff & out_free;
   assign req_ready  = ~building & (~s1_vld_ff | s1_adv);
   assign s1_vld_in  = (req_valid & req_ready) | (s1_vld_ff & ~s1_adv);

   // saturating message length and error check
   assign bcnt_next = (bcnt_ff == CNT_W'(MAX_LEN + 1)) ? bcnt_ff : bcnt_ff + 1'b1;
   assign msg_err   = s1_end_ff & ((parity_count == '0) | (bcnt_next == CNT_W'(MAX_LEN + 1)));

   // lfsr control
   assign par_ctl.fb    = s1_data_ff ^ par_top;
   assign par_ctl.step  = s1_adv & ~msg_err;
   assign par_ctl.clear = s1_adv & msg_err;
   assign par_ctl.shift = drain_emit;

   // result selection and drain sequencing
   always_comb begin
      out_vld_in  = out_vld_ff & ~rsp_ready;
      out_byte_in = out_byte_ff;
      out_par_in  = out_par_ff;
      out_err_in  = out_err_ff;
      out_last_in = out_last_ff;
      drain_in    = drain_ff;
      dcnt_in     = dcnt_ff;
      bcnt_in     = bcnt_ff;
      if (drain_emit) begin
         out_vld_in  = 1'b1;
         out_byte_in = par_top;
         out_par_in  = 1'b1;
         out_err_in  = 1'b0;
         out_last_in = (dcnt_ff == parity_count - 1'b1);
         dcnt_in     = dcnt_ff + 1'b1;
         if (dcnt_ff == parity_count - 1'b1) begin
            drain_in = 1'b0;
         end
      end else if (s1_adv) begin
         out_vld_in  = 1'b1;
         out_byte_in = msg_err ? '0 : s1_data_ff;
         out_par_in  = 1'b0;
         out_err_in  = msg_err;
         out_last_in = msg_err;
         bcnt_in     = s1_end_ff ? '0 : bcnt_next;
         if (s1_end_ff & ~msg_err) begin
            drain_in = 1'b1;
            dcnt_in  = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         drain_ff   <= 1'b0;
         dcnt_ff    <= '0;
         bcnt_ff    <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         drain_ff   <= drain_in;
         dcnt_ff    <= dcnt_in;
         bcnt_ff    <= bcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         s1_data_ff <= req_data_byte;
         s1_end_ff  <= req_msg_end;
      end
      out_byte_ff <= out_byte_in;
      out_par_ff  <= out_par_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_is_parity = out_par_ff;
   assign rsp_error     = out_err_ff;
   assign rsp_out_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/rse_checker.sv =====
// port-level checker for the rs encoder, bound to the top level
`default_nettype none

`include "rs_systematic_encoder_assert.svh"

module rse_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [7:0]                         rsp_out_byte,
   input wire                               rsp_is_parity,
   input wire                               rsp_error,
   input wire                               rsp_out_last
);

   // no result is offered right after reset
   `RSE_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_valid)

   // an error result is a lone zero byte closing the codeword
   `RSE_ASSERT_NOW(a_err_shape, rsp_valid && rsp_error,
      rsp_out_last && !rsp_is_parity && (rsp_out_byte == 8'h00))

   // a codeword closes on a parity byte or an error, never on a message byte
   `RSE_ASSERT_NOW(a_last_kind, rsp_valid && rsp_out_last, rsp_is_parity || rsp_error)

   // a stalled result holds its byte, parity flag and last flag
   `RSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_parity) && $stable(rsp_out_last))

endmodule

bind rs_systematic_encoder rse_checker u_rse_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_is_parity (rsp_is_parity),
   .rsp_error     (rsp_error),
   .rsp_out_last  (rsp_out_last)
);

`default_nettype wire
